### sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table: request and response
// items, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  // Request item: operation 0 is a get, 1 is a put.
  typedef struct packed {
    logic               operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lfu_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a request and restart the scan
    logic rd;      // issue one entry read and advance the scan address
    logic commit;  // apply the decision and load the response register
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;   // the scan address points at the last entry
    logic out_free;  // the response register can take a new item
  } lfu_status_t;

  localparam logic        OP_GET     = 1'b0;
  localparam logic        OP_PUT     = 1'b1;
  localparam logic [31:0] NOT_FOUND  = 32'hFFFF_FFFF;
  localparam logic [4:0]  CAP_RESET  = 5'd16;

endpackage : lfu_pkg

`default_nettype wire

### sv/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer of the LFU cache table: accepts a request, runs the entry scan,
// lets the read pipeline drain and commits once the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_stall,
  output      lfu_cmd_t    cmd,
  input  wire lfu_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (status.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : lfu_ctrl

`default_nettype wire

### sv/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath of the LFU cache table: entry memories, valid bits, the scan that
// finds the key match, the eviction victim and the first free slot, the
// deferred recency-rank correction, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dp
  import lfu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lfu_req_t    req,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data,
  input  wire lfu_cmd_t    cmd,
  output      lfu_status_t status,
  output      logic        rsp_valid,
  input  wire logic        rsp_stall,
  output      lfu_rsp_t    rsp
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (FW > 5) ? FW : 5;

  // Configuration and captured request.
  logic [4:0]  cap_reg;
  lfu_req_t    item;

  // Entry storage.
  logic [31:0]           key_mem  [CAPACITY];
  logic [31:0]           val_mem  [CAPACITY];
  logic [COUNT_BITS-1:0] cnt_mem  [CAPACITY];
  logic [IW-1:0]         rank_mem [CAPACITY];
  logic [CAPACITY-1:0]   valid;

  // Read pipeline.
  logic [IW-1:0]         addr;
  logic                  dv;
  logic [IW-1:0]         d_idx;
  logic [31:0]           key_q;
  logic [31:0]           val_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [IW-1:0]         rank_q;

  // Rank correction left behind by the previous request.
  logic                  pend_act;
  logic                  pend_all;
  logic [IW-1:0]         pend_thr;
  logic [IW-1:0]         pend_skip;

  // Scan results.
  logic                  m_found;
  logic [IW-1:0]         m_slot;
  logic [COUNT_BITS-1:0] m_cnt;
  logic [IW-1:0]         m_rank;
  logic [31:0]           m_val;
  logic                  v_found;
  logic [IW-1:0]         v_slot;
  logic [COUNT_BITS-1:0] v_cnt;
  logic [IW-1:0]         v_rank;
  logic [31:0]           v_key;
  logic                  f_found;
  logic [IW-1:0]         f_slot;
  logic [FW-1:0]         fill;

  // Combinational decision.
  logic                  valid_d;
  logic [IW-1:0]         rank_fix;
  logic                  is_match;
  logic                  is_victim;
  logic [CMPW-1:0]       cfg_ext;
  logic [FW-1:0]         cap_eff;
  logic                  is_get;
  logic                  cap_zero;
  logic                  touch;
  logic                  insert;
  logic                  do_evict;
  logic [IW-1:0]         ins_slot;
  logic [IW-1:0]         wr_slot;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [CAPACITY-1:0]   valid_next;
  lfu_rsp_t              result;

  // --------------------------------------------------------------------------
  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
    end
  end

  always_comb begin
    cfg_ext = CMPW'(cap_reg);
    if (cfg_ext > CMPW'(CAPACITY)) begin
      cap_eff = FW'(CAPACITY);
    end else begin
      cap_eff = FW'(cfg_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Scan address and registered memory reads.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.rd) begin
      addr <= addr + IW'(1);
    end
    d_idx <= addr;
    if (cmd.rd) begin
      key_q  <= key_mem[addr];
      val_q  <= val_mem[addr];
      cnt_q  <= cnt_mem[addr];
      rank_q <= rank_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= cmd.rd;
    end
  end

  assign status.rd_last  = (addr == IW'(CAPACITY - 1));
  assign status.out_free = !rsp_valid || !rsp_stall;

  // --------------------------------------------------------------------------
  // One entry per cycle: correct its rank, then check match and victim.
  always_comb begin
    valid_d = valid[d_idx];
    if (pend_act && (d_idx != pend_skip) && (pend_all || (rank_q < pend_thr))) begin
      rank_fix = rank_q + IW'(1);
    end else begin
      rank_fix = rank_q;
    end
    is_match  = valid_d && (key_q == item.key);
    is_victim = valid_d && (!v_found || (cnt_q < v_cnt) ||
                            ((cnt_q == v_cnt) && (rank_fix > v_rank)));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_found <= 1'b0;
      v_found <= 1'b0;
      f_found <= 1'b0;
      fill    <= '0;
    end else if (dv) begin
      if (is_match) begin
        m_found <= 1'b1;
        m_slot  <= d_idx;
        m_cnt   <= cnt_q;
        m_rank  <= rank_fix;
        m_val   <= val_q;
      end
      if (is_victim) begin
        v_found <= 1'b1;
        v_slot  <= d_idx;
        v_cnt   <= cnt_q;
        v_rank  <= rank_fix;
        v_key   <= key_q;
      end
      if (!valid_d && !f_found) begin
        f_found <= 1'b1;
        f_slot  <= d_idx;
      end
      if (valid_d) begin
        fill <= fill + FW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Decision at commit.
  always_comb begin
    is_get   = (item.operation == OP_GET);
    cap_zero = (cap_eff == '0);
    touch    = m_found && (is_get || !cap_zero);
    insert   = !is_get && !cap_zero && !m_found;
    do_evict = insert && v_found && (fill >= cap_eff);
    if (do_evict && !(f_found && (f_slot < v_slot))) begin
      ins_slot = v_slot;
    end else begin
      ins_slot = f_slot;
    end
    wr_slot = touch ? m_slot : ins_slot;
    cnt_sat = (m_cnt == '1) ? m_cnt : m_cnt + COUNT_BITS'(1);

    result.hit         = touch;
    result.read_value  = (touch && is_get) ? m_val : NOT_FOUND;
    result.evicted     = do_evict;
    result.evicted_key = do_evict ? v_key : '0;
  end

  // The victim is dropped first, so an insert into the same slot sets it again.
  always_comb begin
    valid_next = valid;
    if (do_evict) begin
      valid_next[v_slot] = 1'b0;
    end
    if (insert) begin
      valid_next[ins_slot] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Memory writes. The rank memory takes the corrected ranks during the scan
  // and the rank of the touched or inserted entry at commit.
  always_ff @(posedge clk) begin
    if (dv) begin
      rank_mem[d_idx] <= rank_fix;
    end else if (cmd.commit && (touch || insert)) begin
      rank_mem[wr_slot] <= '0;
    end
    if (cmd.commit && insert) begin
      key_mem[wr_slot] <= item.key;
    end
    if (cmd.commit && (insert || (touch && !is_get))) begin
      val_mem[wr_slot] <= item.value;
    end
    if (cmd.commit && (touch || insert)) begin
      cnt_mem[wr_slot] <= touch ? cnt_sat : COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      pend_act <= 1'b0;
    end else if (cmd.commit) begin
      valid    <= valid_next;
      pend_act <= touch || insert;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_all  <= insert && !do_evict;
      pend_thr  <= touch ? m_rank : v_rank;
      pend_skip <= wr_slot;
    end
  end

  // --------------------------------------------------------------------------
  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  a_commit_after_scan : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !dv && !cmd.rd)
    else $error("commit while the entry scan is still running");

  a_evict_clears : assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_evict && (ins_slot != v_slot) |=> !valid[$past(v_slot)])
    else $error("evicted entry is still valid");

  a_insert_sets : assert property (@(posedge clk) disable iff (rst)
    cmd.commit && insert |=> valid[$past(ins_slot)])
    else $error("inserted entry is not valid");

  a_get_keeps_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.commit && is_get |=> $stable(valid))
    else $error("a get changed the valid bits");

endmodule : lfu_dp

`default_nettype wire

### sv/lfu_cache_table_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_unit
// Key/value table with least-frequently-used replacement and an LRU
// tie-break among entries of equal use count.
// ----------------------------------------------------------------------------
// Usage:
// A request item (get or put, key, value) enters on req when req_valid is high
// and req_stall is low. Every request yields exactly one response item on rsp
// (hit, read_value, evicted, evicted_key), handed over when rsp_valid is high
// and rsp_stall is low. The capacity register is written through cfg_valid /
// cfg_ready / cfg_data; cfg_ready is always high, and writes belong in idle
// periods between requests.
// Each request is served by one scan over all CAPACITY entries, one memory
// read per cycle, that finds the key, the eviction victim and the first free
// slot; the read pipeline then drains and a commit cycle writes the entry and
// loads the response register. A new request is taken only once the previous
// one has been committed.
// Synchronous reset clears all valid bits and sets the capacity to 16. If the
// receiver stalls, the response register holds its item; the next request may
// still be accepted and scanned, and its commit waits until the register is
// free.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_unit
  import lfu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output      logic       req_stall,
  input  wire lfu_req_t   req,
  output      logic       rsp_valid,
  input  wire logic       rsp_stall,
  output      lfu_rsp_t   rsp,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [4:0] cfg_data
);

  lfu_cmd_t    cmd;
  lfu_status_t status;
  logic        cfg_we;

  // The capacity register can always take a write.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The controller sequences scan, drain and commit for one request at a time.
  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the table, the scan trackers and the response register.
  lfu_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule : lfu_cache_table_unit

`default_nettype wire
